### hdl/bsrc_pkg.sv
// ----------------------------------------------------------------------------
// bsrc_pkg
// Shared types and constants for the barometric sensor sequencer and
// compensation block.
// ----------------------------------------------------------------------------
package bsrc_pkg;

    localparam logic [1:0] BUS_NONE       = 2'd0;
    localparam logic [1:0] BUS_CONV_PRESS = 2'd1;
    localparam logic [1:0] BUS_CONV_TEMP  = 2'd2;
    localparam logic [1:0] BUS_READ       = 2'd3;

    typedef enum logic [3:0] {
        CS_OFF   = 4'd0,
        CS_SENS  = 4'd1,
        CS_TEMP  = 4'd2,
        CS_DTSQ  = 4'd3,
        CS_SQ    = 4'd4,
        CS_SQ2   = 4'd5,
        CS_ADD2  = 4'd6,
        CS_APPLY = 4'd7,
        CS_PLO   = 4'd8,
        CS_PHI   = 4'd9,
        CS_PSUM  = 4'd10,
        CS_PSUB  = 4'd11,
        CS_POUT  = 4'd12
    } calc_step_t;

    typedef struct packed {
        logic       load_tick;
        logic [1:0] bus_cmd;
        logic       err_inc;
        logic       latch_raw;
        logic       calc_start;
        logic       calc_en;
        calc_step_t calc_step;
    } bsrc_cmd_t;

endpackage

### hdl/baro_sensor_read_compensate.sv
// ----------------------------------------------------------------------------
// baro_sensor_read_compensate
// Barometric sensor conversion sequencer with first- and second-order
// pressure and temperature compensation.
//
//   channel | signals                                   | direction
//   input   | in_valid, out_stall, transfer_done, adc_value | into block
//   output  | out_valid, in_stall, bus_command, result_valid,
//           | pressure, temperature, error_count        | out of block
//   config  | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// After each accepted tick the block passes through its output state before
// it takes the next; a tick that completes the temperature read first runs
// the compensation steps CS_OFF to CS_POUT on one shared multiplier.
// Reset clears the sequencer, the error count and the wait limits to 9 and 2.
// A stalled beat holds the output; no input is taken until it leaves.
// ----------------------------------------------------------------------------
module baro_sensor_read_compensate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               transfer_done,
    input  logic [23:0]        adc_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         bus_command,
    output logic               result_valid,
    output logic [21:0]        pressure,
    output logic signed [18:0] temperature,
    output logic [31:0]        error_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bsrc_pkg::*;

    localparam logic [2:0] REG_SENS      = 3'd0;
    localparam logic [2:0] REG_OFF       = 3'd1;
    localparam logic [2:0] REG_SENS_TEMP = 3'd2;
    localparam logic [2:0] REG_OFF_TEMP  = 3'd3;
    localparam logic [2:0] REG_REF_TEMP  = 3'd4;
    localparam logic [2:0] REG_SLOPE     = 3'd5;
    localparam logic [2:0] REG_CONV_WAIT = 3'd6;
    localparam logic [2:0] REG_READ_WAIT = 3'd7;

    logic [15:0] sens_reg, off_reg, sens_temp_reg, off_temp_reg;
    logic [15:0] ref_temp_reg, slope_reg, conv_wait_reg, read_wait_reg;
    logic        wr_en;
    logic [15:0] rd_val;
    bsrc_cmd_t   dp_cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = {16'd0, rd_val};

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SENS:      rd_val = sens_reg;
            REG_OFF:       rd_val = off_reg;
            REG_SENS_TEMP: rd_val = sens_temp_reg;
            REG_OFF_TEMP:  rd_val = off_temp_reg;
            REG_REF_TEMP:  rd_val = ref_temp_reg;
            REG_SLOPE:     rd_val = slope_reg;
            REG_CONV_WAIT: rd_val = conv_wait_reg;
            REG_READ_WAIT: rd_val = read_wait_reg;
            default:       rd_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg      <= '0;
            off_reg       <= '0;
            sens_temp_reg <= '0;
            off_temp_reg  <= '0;
            ref_temp_reg  <= '0;
            slope_reg     <= '0;
            conv_wait_reg <= 16'd9;
            read_wait_reg <= 16'd2;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_SENS:      sens_reg      <= pwdata[15:0];
                REG_OFF:       off_reg       <= pwdata[15:0];
                REG_SENS_TEMP: sens_temp_reg <= pwdata[15:0];
                REG_OFF_TEMP:  off_temp_reg  <= pwdata[15:0];
                REG_REF_TEMP:  ref_temp_reg  <= pwdata[15:0];
                REG_SLOPE:     slope_reg     <= pwdata[15:0];
                REG_CONV_WAIT: conv_wait_reg <= pwdata[15:0];
                REG_READ_WAIT: read_wait_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    bsrc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .transfer_done   (transfer_done),
        .conv_wait_ticks (conv_wait_reg),
        .read_wait_ticks (read_wait_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .dp_cmd          (dp_cmd)
    );

    bsrc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .adc_value       (adc_value),
        .sens_coeff      (sens_reg),
        .off_coeff       (off_reg),
        .sens_temp_coeff (sens_temp_reg),
        .off_temp_coeff  (off_temp_reg),
        .ref_temp        (ref_temp_reg),
        .temp_slope      (slope_reg),
        .bus_command     (bus_command),
        .result_valid    (result_valid),
        .pressure        (pressure),
        .temperature     (temperature),
        .error_count     (error_count)
    );

endmodule

### hdl/bsrc_ctrl.sv
// ----------------------------------------------------------------------------
// bsrc_ctrl
// Handshake controller, conversion sequencer and compensation step counter.
// ----------------------------------------------------------------------------
module bsrc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               transfer_done,
    input  logic [15:0]        conv_wait_ticks,
    input  logic [15:0]        read_wait_ticks,
    output logic               out_valid,
    input  logic               out_stall,
    output bsrc_pkg::bsrc_cmd_t dp_cmd
);
    import bsrc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_OUT  = 3'b100
    } ctrl_state_t;

    typedef enum logic [4:0] {
        SQ_START = 5'b00001,
        SQ_PCONV = 5'b00010,
        SQ_PREAD = 5'b00100,
        SQ_TCONV = 5'b01000,
        SQ_TREAD = 5'b10000
    } seq_state_t;

    ctrl_state_t state_reg, state_next;
    seq_state_t  seq_reg, seq_next;
    logic [15:0] tick_reg, tick_next, tick_inc;
    calc_step_t  step_reg, step_next;
    logic        accept;
    logic [1:0]  bus_cmd;
    logic        err_inc, latch_raw, calc_start;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign tick_inc  = tick_reg + 16'd1;

    always_comb
    begin
        seq_next   = seq_reg;
        tick_next  = tick_inc;
        bus_cmd    = BUS_NONE;
        err_inc    = 1'b0;
        latch_raw  = 1'b0;
        calc_start = 1'b0;
        unique case (seq_reg)
            SQ_START:
            begin
                bus_cmd   = BUS_CONV_PRESS;
                tick_next = '0;
                seq_next  = SQ_PCONV;
            end
            SQ_PCONV, SQ_TCONV:
            begin
                if (tick_inc > conv_wait_ticks)
                begin
                    if (transfer_done)
                    begin
                        bus_cmd   = BUS_READ;
                        tick_next = '0;
                        seq_next  = (seq_reg == SQ_PCONV) ? SQ_PREAD : SQ_TREAD;
                    end
                    else
                    begin
                        err_inc  = 1'b1;
                        seq_next = SQ_START;
                    end
                end
            end
            SQ_PREAD:
            begin
                if (transfer_done)
                begin
                    latch_raw = 1'b1;
                    bus_cmd   = BUS_CONV_TEMP;
                    tick_next = '0;
                    seq_next  = SQ_TCONV;
                end
                else if (tick_inc > read_wait_ticks)
                begin
                    err_inc  = 1'b1;
                    seq_next = SQ_START;
                end
            end
            SQ_TREAD:
            begin
                if (transfer_done)
                begin
                    calc_start = 1'b1;
                    tick_next  = '0;
                    seq_next   = SQ_START;
                end
                else if (tick_inc > read_wait_ticks)
                begin
                    err_inc  = 1'b1;
                    seq_next = SQ_START;
                end
            end
            default:
            begin
                seq_next = SQ_START;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next  = CS_OFF;
                    state_next = calc_start ? ST_CALC : ST_OUT;
                end
            end
            ST_CALC:
            begin
                if (step_reg == CS_POUT)
                    state_next = ST_OUT;
                else
                    step_next = calc_step_t'(4'(step_reg) + 4'd1);
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd.load_tick  = accept;
        dp_cmd.bus_cmd    = bus_cmd;
        dp_cmd.err_inc    = accept && err_inc;
        dp_cmd.latch_raw  = accept && latch_raw;
        dp_cmd.calc_start = accept && calc_start;
        dp_cmd.calc_en    = (state_reg == ST_CALC);
        dp_cmd.calc_step  = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= SQ_START;
            tick_reg  <= '0;
            step_reg  <= CS_OFF;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (accept)
            begin
                seq_reg  <= seq_next;
                tick_reg <= tick_next;
            end
        end
    end

endmodule

### hdl/bsrc_dp.sv
// ----------------------------------------------------------------------------
// bsrc_dp
// Compensation datapath around one shared signed multiplier, with the
// raw pressure store and the result registers.
// ----------------------------------------------------------------------------
module bsrc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  bsrc_pkg::bsrc_cmd_t dp_cmd,
    input  logic [23:0]         adc_value,
    input  logic [15:0]         sens_coeff,
    input  logic [15:0]         off_coeff,
    input  logic [15:0]         sens_temp_coeff,
    input  logic [15:0]         off_temp_coeff,
    input  logic [15:0]         ref_temp,
    input  logic [15:0]         temp_slope,
    output logic [1:0]          bus_command,
    output logic                result_valid,
    output logic [21:0]         pressure,
    output logic signed [18:0]  temperature,
    output logic [31:0]         error_count
);
    import bsrc_pkg::*;

    localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
    localparam logic signed [19:0] TEMP_COLD  = -20'sd1500;
    localparam logic signed [19:0] TEMP_LO    = -20'sd262144;
    localparam logic signed [19:0] TEMP_HI    = 20'sd262143;
    localparam logic signed [63:0] PRESS_MAX  = 64'sd4194303;

    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                     input int k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

    logic [23:0]        raw_reg;
    logic signed [24:0] dt_reg;
    logic signed [39:0] off_reg, sens_reg;
    logic [39:0]        off2_reg, sens2_reg;
    logic signed [19:0] t_reg;
    logic [17:0]        t2_reg;
    logic               low_reg;
    logic signed [63:0] acc_reg;
    logic signed [47:0] q_reg;
    logic signed [51:0] prod_reg;

    logic signed [25:0] mul_a, mul_b;
    logic signed [19:0] tm, tp;
    logic signed [63:0] prod64, t_div, p64;
    logic [39:0]        sq;
    logic [41:0]        sq5;
    logic [43:0]        sq7, sq11;
    logic signed [18:0] t_sat;

    assign prod64 = 64'(prod_reg);
    assign tm     = t_reg - TEMP_REF;
    assign tp     = t_reg - TEMP_COLD;
    assign t_div  = trunc_shr(prod64, 23);
    assign sq     = prod_reg[39:0];
    assign sq5    = (42'(sq) << 2) + 42'(sq);
    assign sq7    = (44'(sq) << 3) - 44'(sq);
    assign sq11   = (44'(sq) << 3) + (44'(sq) << 1) + 44'(sq);
    assign p64    = trunc_shr(64'(q_reg), 15);

    always_comb
    begin
        if (t_reg < TEMP_LO)
            t_sat = 19'(TEMP_LO);
        else if (t_reg > TEMP_HI)
            t_sat = 19'(TEMP_HI);
        else
            t_sat = t_reg[18:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (dp_cmd.calc_step)
            CS_OFF:
            begin
                mul_a = 26'(dt_reg);
                mul_b = 26'({1'b0, off_temp_coeff});
            end
            CS_SENS:
            begin
                mul_a = 26'(dt_reg);
                mul_b = 26'({1'b0, sens_temp_coeff});
            end
            CS_TEMP:
            begin
                mul_a = 26'(dt_reg);
                mul_b = 26'({1'b0, temp_slope});
            end
            CS_DTSQ:
            begin
                mul_a = 26'(dt_reg);
                mul_b = 26'(dt_reg);
            end
            CS_SQ:
            begin
                mul_a = 26'(tm);
                mul_b = 26'(tm);
            end
            CS_SQ2:
            begin
                mul_a = 26'(tp);
                mul_b = 26'(tp);
            end
            CS_PLO:
            begin
                mul_a = 26'({1'b0, raw_reg});
                mul_b = 26'({1'b0, sens_reg[19:0]});
            end
            CS_PHI:
            begin
                mul_a = 26'({1'b0, raw_reg});
                mul_b = 26'($signed(sens_reg[39:20]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch_raw)
            raw_reg <= adc_value;
        if (dp_cmd.calc_start)
            dt_reg <= 25'($signed({1'b0, adc_value})) - 25'($signed({1'b0, ref_temp, 8'd0}));
        if (dp_cmd.calc_en)
        begin
            prod_reg <= mul_a * mul_b;
            case (dp_cmd.calc_step)
                CS_SENS:
                    off_reg <= 40'($signed({1'b0, off_coeff, 16'd0}))
                               + 40'(trunc_shr(prod64, 7));
                CS_TEMP:
                    sens_reg <= 40'($signed({1'b0, sens_coeff, 15'd0}))
                                + 40'(trunc_shr(prod64, 8));
                CS_DTSQ:
                begin
                    t_reg   <= TEMP_REF + 20'(t_div);
                    low_reg <= t_div[63];
                end
                CS_SQ:
                    t2_reg <= prod_reg[48:31];
                CS_SQ2:
                begin
                    off2_reg  <= 40'(sq5 >> 1);
                    sens2_reg <= 40'(sq5 >> 2);
                end
                CS_ADD2:
                begin
                    if (t_reg < TEMP_COLD)
                    begin
                        off2_reg  <= off2_reg + 40'(sq7);
                        sens2_reg <= sens2_reg + 40'(sq11 >> 1);
                    end
                end
                CS_APPLY:
                begin
                    if (low_reg)
                    begin
                        t_reg    <= t_reg - 20'($signed({1'b0, t2_reg}));
                        off_reg  <= off_reg - $signed(off2_reg);
                        sens_reg <= sens_reg - $signed(sens2_reg);
                    end
                end
                CS_PHI:
                    acc_reg <= prod64;
                CS_PSUM:
                    acc_reg <= acc_reg + (prod64 <<< 20);
                CS_PSUB:
                    q_reg <= 48'(trunc_shr(acc_reg, 21)) - 48'(off_reg);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_command  <= BUS_NONE;
            result_valid <= 1'b0;
            pressure     <= '0;
            temperature  <= '0;
            error_count  <= '0;
        end
        else
        begin
            if (dp_cmd.load_tick)
            begin
                bus_command  <= dp_cmd.bus_cmd;
                result_valid <= 1'b0;
                pressure     <= '0;
                temperature  <= '0;
                if (dp_cmd.err_inc)
                    error_count <= error_count + 32'd1;
            end
            if (dp_cmd.calc_en && (dp_cmd.calc_step == CS_POUT) && (p64 > 64'sd0))
            begin
                result_valid <= 1'b1;
                pressure     <= (p64 > PRESS_MAX) ? 22'h3FFFFF : p64[21:0];
                temperature  <= t_sat;
            end
        end
    end

endmodule

### tb/sv/baro_sensor_read_compensate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_read_compensate_tb
// Self-checking regression for the barometric sequencer and compensation
// block. Ticks are driven with random gaps and output stalls. Every output
// beat is checked against an in-bench model of the sequencer and the
// compensation arithmetic. Calibration and wait limits are changed only
// while the block is idle.
// ----------------------------------------------------------------------------
module baro_sensor_read_compensate_tb;
    import bsrc_pkg::*;

    localparam int REG_C1 = 0, REG_C2 = 1, REG_C3 = 2, REG_C4 = 3;
    localparam int REG_C5 = 4, REG_C6 = 5, REG_CONV = 6, REG_READ = 7;
    localparam int ST_START = 0, ST_CONV_P = 1, ST_READ_P = 2;
    localparam int ST_CONV_T = 3, ST_READ_T = 4;
    localparam int SETTLE = 24;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               valid;
        logic [21:0]        press;
        logic signed [18:0] temp;
        logic [31:0]        errs;
    } tick_result_t;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic               transfer_done = 0;
    logic [23:0]        adc_value = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [1:0]         bus_command;
    logic               result_valid;
    logic [21:0]        pressure;
    logic signed [18:0] temperature;
    logic [31:0]        error_count;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [4:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    baro_sensor_read_compensate DUT (.*);

    // model state
    logic [15:0]  cal [0:7];
    int           seq;
    logic [15:0]  ticks;
    logic [23:0]  raw_press;
    logic [31:0]  timeouts;
    tick_result_t expected_ticks [$];

    int     fails = 0;
    int     sent = 0;
    bit     quiet = 0;
    bit     hold_req = 0;
    longint cycles = 0;

    initial forever #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("baro_sensor_read_compensate regression: fail");
            $finish;
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1;
                for (n = 0; n < 400; n++)
                    @(negedge clk);
                hold_req = 0;
                out_stall <= 0;
            end
            else
                out_stall <= (!quiet && $urandom_range(99) < 31);
        end
    end

    always @(posedge clk)
    begin
        tick_result_t e, a;
        if (rst_n && out_valid && !out_stall)
        begin
            a = '{bus_command, result_valid, pressure, temperature, error_count};
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, a);
                fails++;
            end
            else
            begin
                e = expected_ticks.pop_front();
                if (e.cmd !== a.cmd)
                begin
                    $display("%0t: bus_command exp %0d got %0d", $time, e.cmd, a.cmd);
                    fails++;
                end
                if (e.valid !== a.valid)
                begin
                    $display("%0t: result_valid exp %0d got %0d", $time, e.valid, a.valid);
                    fails++;
                end
                if (e.press !== a.press)
                begin
                    $display("%0t: pressure exp %0d got %0d", $time, e.press, a.press);
                    fails++;
                end
                if (e.temp !== a.temp)
                begin
                    $display("%0t: temperature exp %0d got %0d", $time, e.temp, a.temp);
                    fails++;
                end
                if (e.errs !== a.errs)
                begin
                    $display("%0t: error_count exp %0d got %0d", $time, e.errs, a.errs);
                    fails++;
                end
            end
        end
    end

    function automatic bit compensate(input logic [23:0] d2, output logic [21:0] pr,
                                      output logic [18:0] tp);
        longint dt, off, sens, t, t2, sq, off2, sens2, sq2, p;
        dt   = longint'(d2) - longint'(cal[REG_C5]) * 256;
        off  = longint'(cal[REG_C2]) * 65536 + (longint'(cal[REG_C4]) * dt) / 128;
        sens = longint'(cal[REG_C1]) * 32768 + (longint'(cal[REG_C3]) * dt) / 256;
        t    = 2000 + (dt * longint'(cal[REG_C6])) / 8388608;
        if (t < 2000)
        begin
            t2    = (dt * dt) / 64'sd2147483648;
            sq    = (t - 2000) * (t - 2000);
            off2  = sq * 5 / 2;
            sens2 = sq * 5 / 4;
            if (t < -1500)
            begin
                sq2   = (t + 1500) * (t + 1500);
                off2  = off2 + 7 * sq2;
                sens2 = sens2 + 11 * sq2 / 2;
            end
            t    = t - t2;
            off  = off - off2;
            sens = sens - sens2;
        end
        p = (longint'(raw_press) * sens / 2097152 - off) / 32768;
        pr = 0;
        tp = 0;
        if (p <= 0)
            return 0;
        if (p > 4194303)
            p = 4194303;
        if (t < -262144)
            t = -262144;
        if (t > 262143)
            t = 262143;
        pr = p[21:0];
        tp = t[18:0];
        return 1;
    endfunction

    function automatic void predict_tick(input logic done, input logic [23:0] adc);
        tick_result_t r;
        r = '0;
        ticks = ticks + 16'd1;
        case (seq)
            ST_START:
            begin
                r.cmd = BUS_CONV_PRESS;
                ticks = 0;
                seq = ST_CONV_P;
            end
            ST_CONV_P, ST_CONV_T:
                if (ticks > cal[REG_CONV])
                begin
                    if (done)
                    begin
                        r.cmd = BUS_READ;
                        ticks = 0;
                        seq = seq + 1;
                    end
                    else
                    begin
                        seq = ST_START;
                        timeouts = timeouts + 1;
                    end
                end
            ST_READ_P:
                if (done)
                begin
                    raw_press = adc;
                    r.cmd = BUS_CONV_TEMP;
                    ticks = 0;
                    seq = ST_CONV_T;
                end
                else if (ticks > cal[REG_READ])
                begin
                    seq = ST_START;
                    timeouts = timeouts + 1;
                end
            ST_READ_T:
                if (done)
                begin
                    ticks = 0;
                    seq = ST_START;
                    r.valid = compensate(adc, r.press, r.temp);
                end
                else if (ticks > cal[REG_READ])
                begin
                    seq = ST_START;
                    timeouts = timeouts + 1;
                end
            default:
                seq = ST_START;
        endcase
        r.errs = timeouts;
        expected_ticks.push_back(r);
    endfunction

    task automatic send_tick(input logic done, input logic [23:0] adc);
        int g;
        if (!quiet && $urandom_range(99) < 31)
        begin
            @(negedge clk);
            in_valid <= 0;
            for (g = $urandom_range(3); g > 0; g--)
                @(negedge clk);
        end
        else
            @(negedge clk);
        in_valid <= 1;
        transfer_done <= done;
        adc_value <= adc;
        do
            @(posedge clk);
        while (in_stall);
        predict_tick(done, adc);
        sent++;
    endtask

    task automatic drain();
        int n;
        @(negedge clk);
        in_valid <= 0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        for (n = 0; n < SETTLE; n++)
            @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [15:0] v);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= 5'(4 * idx);
        pwdata <= {16'h0, v};
        @(negedge clk);
        penable <= 1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        cal[idx] = v;
    endtask

    task automatic set_cal(input logic [15:0] c1, c2, c3, c4, c5, c6);
        write_reg(REG_C1, c1);
        write_reg(REG_C2, c2);
        write_reg(REG_C3, c3);
        write_reg(REG_C4, c4);
        write_reg(REG_C5, c5);
        write_reg(REG_C6, c6);
    endtask

    // one full well-formed conversion pair, done held high throughout
    task automatic run_pair(input logic [23:0] d1, input logic [23:0] d2);
        bit left;
        left = 0;
        while (!(left && seq == ST_START))
        begin
            send_tick(1, seq == ST_READ_P ? d1 : (seq == ST_READ_T ? d2 : 24'($urandom)));
            left = 1;
        end
    endtask

    function automatic logic [23:0] near(input int centre, input int span);
        return 24'(centre - span + int'($urandom_range(2 * span)));
    endfunction

    task automatic test_reset_defaults();
        run_pair(24'd9085466, 24'd8569150);
    endtask

    task automatic test_directed();
        drain();
        set_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        write_reg(REG_CONV, 0);
        write_reg(REG_READ, 0);
        run_pair(24'd9085466, 24'd8569150);
        run_pair(24'hFFFFFF, 24'hFFFFFF);
        run_pair(24'd0, 24'd0);
        run_pair(24'hFFFFFF, 24'd0);
        run_pair(24'd9085466, 24'd7000000);
        run_pair(24'hAAAAAA, 24'h555555);
        drain();
        set_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_pair(24'hFFFFFF, 24'd0);
        run_pair(24'h555555, 24'hAAAAAA);
    endtask

    task automatic test_timeouts();
        int k;
        drain();
        set_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        write_reg(REG_CONV, 2);
        write_reg(REG_READ, 1);
        for (k = 0; k < 8; k++)
            send_tick(0, 24'($urandom));
        send_tick(1, 0);
        for (k = 0; k < 3; k++)
            send_tick(1, 0);
        for (k = 0; k < 4; k++)
            send_tick(0, 0);
        drain();
        write_reg(REG_CONV, 16'hFFFF);
        write_reg(REG_READ, 16'hFFFF);
        for (k = 0; k < 300; k++)
            send_tick(1'($urandom_range(1)), 24'($urandom));
        drain();
        write_reg(REG_CONV, 1);
        run_pair(24'd9000000, 24'd8000000);
    endtask

    task automatic test_random(input int count);
        int kind;
        int k;
        while (sent < count)
        begin
            if ($urandom_range(99) < 4)
            begin
                drain();
                kind = $urandom_range(3);
                if (kind == 0)
                    set_cal(16'(near(40000, 3000)), 16'(near(37000, 3000)),
                            16'(near(23000, 3000)), 16'(near(23000, 3000)),
                            16'(near(33000, 3000)), 16'(near(28000, 3000)));
                else
                    set_cal(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
                write_reg(REG_CONV, 16'($urandom_range(4)));
                write_reg(REG_READ, 16'($urandom_range(3)));
            end
            if ($urandom_range(99) < 80)
                run_pair(near(9000000, 2500000), near(8500000, 4000000));
            else
                for (k = $urandom_range(1, 6); k > 0; k--)
                    send_tick($urandom_range(99) < 60, 24'($urandom));
        end
    endtask

    task automatic test_backpressure();
        int k;
        hold_req = 1;
        for (k = 0; k < 40; k++)
            send_tick(1, near(8500000, 500000));
        drain();
    endtask

    task automatic test_no_idle();
        quiet = 1;
        test_random(sent + 200);
        quiet = 0;
    endtask

    initial
    begin
        int n;
        cal[REG_C1] = 0; cal[REG_C2] = 0; cal[REG_C3] = 0; cal[REG_C4] = 0;
        cal[REG_C5] = 0; cal[REG_C6] = 0; cal[REG_CONV] = 9; cal[REG_READ] = 2;
        seq = ST_START;
        ticks = 0;
        raw_press = 0;
        timeouts = 0;
        for (n = 0; n < 12; n++)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        test_reset_defaults();
        test_directed();
        test_timeouts();
        test_backpressure();
        test_no_idle();
        test_random(1550);
        drain();
        if (fails == 0)
            $display("baro_sensor_read_compensate regression: pass");
        else
            $display("baro_sensor_read_compensate regression: fail");
        $finish;
    end
endmodule

### sim.f
hdl/bsrc_pkg.sv
hdl/bsrc_ctrl.sv
hdl/bsrc_dp.sv
hdl/baro_sensor_read_compensate.sv
tb/sv/baro_sensor_read_compensate_tb.sv
